// ===== rtl/tmma_pkg.sv =====
// shared constants and types for the temperature min/max alarm monitor
package tmma_pkg;

    localparam int SAMPLE_BITS     = 9;
    localparam int HOLDOFF_SECONDS = 60;
    localparam int HOLD_BITS       = $clog2(HOLDOFF_SECONDS + 1);
    localparam int ALARM_BITS      = 2;
    localparam int CFG_INDEX_BITS  = 2;

    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 3 * SAMPLE_BITS + ALARM_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] temp_t;
    typedef logic [HOLD_BITS-1:0]          hold_t;

    typedef enum logic [ALARM_BITS-1:0] {
        ALARM_NONE = 2'd0,
        ALARM_LOW  = 2'd1,
        ALARM_HIGH = 2'd2
    } alarm_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LOW_THRESHOLD  = 2'd0,
        REG_HIGH_THRESHOLD = 2'd1
    } cfg_index_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    localparam temp_t LOW_THRESHOLD_RESET  = temp_t'(0);
    localparam temp_t HIGH_THRESHOLD_RESET = temp_t'(100);
    localparam hold_t HOLD_LOAD            = hold_t'(HOLDOFF_SECONDS);

endpackage

// ===== rtl/temperature_min_max_alarm.sv =====
// temperature min/max alarm monitor: top level
//
// Each input beat is a temperature sample or a one-second tick and yields exactly one
// result beat, registered in the cycle after acceptance, with the current, minimum and
// maximum temperature and an alarm code. The whole update is a single compare-and-select
// pass from the state registers into the output register, so a beat is taken every
// cycle while the output is free or being drained (throughput one beat per cycle).
// The first sample loads all three temperatures without an alarm check. After an alarm
// the shared holdoff counter blocks alarms for 60 ticks; a threshold write clears it.
// Thresholds are to be written only while no beat is in flight, which the block does
// not enforce; cfg_ready is always high and indexes other than 0 and 1 are ignored.
module temperature_min_max_alarm (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tmma_pkg::S_TDATA_BITS-1:0]   s_tdata,   // sample, zero pad
    input  logic                                s_tuser,   // cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tmma_pkg::M_TDATA_BITS-1:0]   m_tdata,   // current_temp, minimum_temp,
                                                           // maximum_temp, alarm, zero pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tmma_pkg::SAMPLE_BITS-1:0]    cfg_data
);
    import tmma_pkg::*;

    logic   seen_first_reg, seen_first_next;
    temp_t  current_reg, current_next;
    temp_t  minimum_reg, minimum_next;
    temp_t  maximum_reg, maximum_next;
    hold_t  hold_reg, hold_next;
    temp_t  low_thr_reg, low_thr_next;
    temp_t  high_thr_reg, high_thr_next;
    logic   m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0] m_data_reg, m_data_next;

    logic   s_fire;
    logic   cfg_fire;
    temp_t  sample;
    alarm_t alarm;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign sample    = temp_t'(s_tdata[SAMPLE_BITS-1:0]);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        seen_first_next = seen_first_reg;
        current_next    = current_reg;
        minimum_next    = minimum_reg;
        maximum_next    = maximum_reg;
        hold_next       = hold_reg;
        low_thr_next    = low_thr_reg;
        high_thr_next   = high_thr_reg;
        alarm           = ALARM_NONE;

        if (s_fire) begin
            if (cmd_t'(s_tuser) == CMD_TICK) begin
                if (hold_reg != '0) begin
                    hold_next = hold_reg - hold_t'(1);
                end
            end else if (!seen_first_reg) begin
                seen_first_next = 1'b1;
                current_next    = sample;
                minimum_next    = sample;
                maximum_next    = sample;
            end else begin
                current_next = sample;
                if (sample < minimum_reg) begin
                    minimum_next = sample;
                end
                if (sample > maximum_reg) begin
                    maximum_next = sample;
                end
                if (hold_reg == '0) begin
                    if (minimum_next < low_thr_reg) begin
                        alarm = ALARM_LOW;
                    end else if (maximum_next > high_thr_reg) begin
                        alarm = ALARM_HIGH;
                    end
                    if (alarm != ALARM_NONE) begin
                        hold_next = HOLD_LOAD;
                    end
                end
            end
        end

        if (cfg_fire) begin
            case (cfg_index_t'(cfg_index))
                REG_LOW_THRESHOLD: begin
                    low_thr_next = temp_t'(cfg_data);
                    hold_next    = '0;
                end
                REG_HIGH_THRESHOLD: begin
                    high_thr_next = temp_t'(cfg_data);
                    hold_next     = '0;
                end
                default: begin
                end
            endcase
        end

        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = M_TDATA_BITS'({alarm, maximum_next, minimum_next, current_next});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_first_reg <= 1'b0;
            current_reg    <= '0;
            minimum_reg    <= '0;
            maximum_reg    <= '0;
            hold_reg       <= '0;
            low_thr_reg    <= LOW_THRESHOLD_RESET;
            high_thr_reg   <= HIGH_THRESHOLD_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            seen_first_reg <= seen_first_next;
            current_reg    <= current_next;
            minimum_reg    <= minimum_next;
            maximum_reg    <= maximum_next;
            hold_reg       <= hold_next;
            low_thr_reg    <= low_thr_next;
            high_thr_reg   <= high_thr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
